/* hw/rtl/ihfe_pkg.sv */
// ----------------------------------------------------------------------------
// ihfe_pkg: shared types and constants for the ICMP header field extractor
// Message positions, ICMP codes and the result record layout.
// ----------------------------------------------------------------------------
package ihfe_pkg;

  localparam int unsigned CNT_W = 16;

  // byte positions within the ICMP message
  localparam logic [CNT_W-1:0] POS_TYPE      = 16'd0;
  localparam logic [CNT_W-1:0] POS_CODE      = 16'd1;
  localparam logic [CNT_W-1:0] POS_IDENT_HI  = 16'd4;
  localparam logic [CNT_W-1:0] POS_IDENT_LO  = 16'd5;
  localparam logic [CNT_W-1:0] POS_IHL       = 16'd8;   // IHL nibble of the quoted IPv4 header
  localparam logic [CNT_W-1:0] POS_PROTO     = 16'd17;
  localparam logic [CNT_W-1:0] POS_SRC_FIRST = 16'd20;
  localparam logic [CNT_W-1:0] POS_SRC_LAST  = 16'd23;
  localparam logic [CNT_W-1:0] POS_DST_FIRST = 16'd24;
  localparam logic [CNT_W-1:0] POS_DST_LAST  = 16'd27;

  // length checks, expressed on position of final byte (length - 1)
  localparam logic [CNT_W-1:0] POS_MIN_VALID = 16'd2;   // length > 2
  localparam logic [CNT_W-1:0] POS_MIN_IDENT = 16'd5;   // length > 5
  localparam logic [CNT_W-1:0] POS_MIN_QUOTE = 16'd27;  // length >= 8 + 20
  localparam logic [CNT_W-1:0] POS_UDP_END   = 16'd15;  // length >= 8 + 4*IHL + 8

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // ICMP types and codes
  localparam logic [7:0] TYPE_ECHO_REPLY  = 8'd0;
  localparam logic [7:0] TYPE_UNREACH     = 8'd3;
  localparam logic [7:0] TYPE_ECHO_REQ    = 8'd8;
  localparam logic [7:0] TYPE_TS_REQ      = 8'd13;
  localparam logic [7:0] TYPE_TS_REPLY    = 8'd14;
  localparam logic [7:0] TYPE_INFO_REQ    = 8'd15;
  localparam logic [7:0] TYPE_INFO_REPLY  = 8'd16;
  localparam logic [7:0] CODE_ZERO        = 8'd0;
  localparam logic [7:0] CODE_PORT_UNR    = 8'd3;
  localparam logic [7:0] PROTO_UDP        = 8'd17;

  localparam int unsigned OUT_TDATA_W = 144;

  typedef struct packed {
    logic [7:0]  quoted_proto;
    logic [15:0] quoted_dst_port;
    logic [15:0] quoted_src_port;
    logic [31:0] quoted_dst_addr;
    logic [31:0] quoted_src_addr;
    logic        unreach_valid;
    logic [15:0] echo_ident;
    logic [7:0]  msg_code;
    logic [7:0]  msg_type;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  function automatic logic ident_type(input logic [7:0] t);
    ident_type = (t == TYPE_ECHO_REPLY) || (t == TYPE_ECHO_REQ) ||
                 (t == TYPE_TS_REQ)     || (t == TYPE_TS_REPLY) ||
                 (t == TYPE_INFO_REQ)   || (t == TYPE_INFO_REPLY);
  endfunction

endpackage

/* hw/rtl/icmp_header_field_extractor.sv */
// ----------------------------------------------------------------------------
// icmp_header_field_extractor: ICMP header and quoted UDP field extractor
// Takes an ICMP message a byte per beat and emits one record per message.
// ----------------------------------------------------------------------------
// Each input beat carries one message byte, starting at the ICMP type byte,
// with in_tlast on the final byte. A byte only updates the position counter
// and the capture registers, so one beat is taken per clock, one byte per
// cycle, while in_tready is high. On the final beat the record is formed
// from the captured fields (including that byte) and registered into the
// output side, a two-entry buffer, so in_tready is a flop and drops only
// when two records are held. The position count saturates at 65535; bytes
// past the quoted UDP ports are ignored. Messages of two bytes or less give
// an all-zero record. Quoted addresses and ports are reported only for
// port-unreachable messages of 28 bytes or more that quote UDP and hold a
// full UDP header; the identifier only for echo, timestamp and info messages
// with code 0 and at least six bytes.
// ----------------------------------------------------------------------------
module icmp_header_field_extractor
  import ihfe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input beat
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,   // last_byte
  // result beat
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] msg_type, [15:8] msg_code, [31:16] echo_ident, [32] unreach_valid,
  // [64:33] quoted_src_addr, [96:65] quoted_dst_addr,
  // [112:97] quoted_src_port, [128:113] quoted_dst_port,
  // [136:129] quoted_proto, [143:137] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic beat_acc;
  logic rec_valid;
  rec_t rec;
  rec_t out_rec;

  assign beat_acc = in_tvalid && in_tready;

  ihfe_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_acc  (beat_acc),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  ihfe_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_valid),
    .push_rec  (rec),
    .can_push  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (out_rec)
  );

  // struct is laid out with msg_type in the low bits; pad to whole bytes
  assign out_tdata = {{(OUT_TDATA_W - REC_W){1'b0}}, out_rec};

endmodule

/* hw/rtl/ihfe_capture.sv */
// ----------------------------------------------------------------------------
// ihfe_capture: per-message byte counter and field capture
// Captures header fields as bytes pass and forms the record on the final beat.
// ----------------------------------------------------------------------------
module ihfe_capture
  import ihfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat_acc,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       rec_valid,
  output rec_t       rec
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [15:0]      ident_r, ident_nxt;
  logic [3:0]       ihl_r, ihl_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;
  logic [15:0]      sport_r, sport_nxt;
  logic [15:0]      dport_r, dport_nxt;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] udp_need;
  logic             unr_ok;

  // field capture; values include the current byte
  always_comb begin
    type_nxt  = type_r;
    code_nxt  = code_r;
    ident_nxt = ident_r;
    ihl_nxt   = ihl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;

    if (cnt_r == POS_TYPE)     type_nxt        = data_byte;
    if (cnt_r == POS_CODE)     code_nxt        = data_byte;
    if (cnt_r == POS_IDENT_HI) ident_nxt[15:8] = data_byte;
    if (cnt_r == POS_IDENT_LO) ident_nxt[7:0]  = data_byte;
    if (cnt_r == POS_IHL)      ihl_nxt         = data_byte[3:0];
    if (cnt_r == POS_PROTO)    proto_nxt       = data_byte;

    // addresses: first byte lands in the top lane
    if (cnt_r >= POS_SRC_FIRST && cnt_r <= POS_SRC_LAST) begin
      case (cnt_r[1:0])
        2'd0:    src_nxt[31:24] = data_byte;
        2'd1:    src_nxt[23:16] = data_byte;
        2'd2:    src_nxt[15:8]  = data_byte;
        default: src_nxt[7:0]   = data_byte;
      endcase
    end
    if (cnt_r >= POS_DST_FIRST && cnt_r <= POS_DST_LAST) begin
      case (cnt_r[1:0])
        2'd0:    dst_nxt[31:24] = data_byte;
        2'd1:    dst_nxt[23:16] = data_byte;
        2'd2:    dst_nxt[15:8]  = data_byte;
        default: dst_nxt[7:0]   = data_byte;
      endcase
    end

    // ports follow the quoted IP header; IHL may arrive on this very beat
    if (cnt_r == base)               sport_nxt[15:8] = data_byte;
    if (cnt_r == base + 16'd1)       sport_nxt[7:0]  = data_byte;
    if (cnt_r == base + 16'd2)       dport_nxt[15:8] = data_byte;
    if (cnt_r == base + 16'd3)       dport_nxt[7:0]  = data_byte;
  end

  assign base     = POS_IHL + {10'd0, ihl_nxt, 2'b00};
  assign udp_need = POS_UDP_END + {10'd0, ihl_nxt, 2'b00};
  assign cnt_nxt  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 16'd1;

  assign unr_ok = (cnt_r >= POS_MIN_QUOTE) && (cnt_r >= udp_need) &&
                  (proto_nxt == PROTO_UDP);

  // record assembly
  always_comb begin
    rec = '0;
    if (cnt_r >= POS_MIN_VALID) begin
      rec.msg_type = type_nxt;
      rec.msg_code = code_nxt;
      if (type_nxt == TYPE_UNREACH && code_nxt == CODE_PORT_UNR) begin
        if (unr_ok) begin
          rec.unreach_valid   = 1'b1;
          rec.quoted_src_addr = src_nxt;
          rec.quoted_dst_addr = dst_nxt;
          rec.quoted_src_port = sport_nxt;
          rec.quoted_dst_port = dport_nxt;
          rec.quoted_proto    = proto_nxt;
        end
      end else if (ident_type(type_nxt) && code_nxt == CODE_ZERO &&
                   cnt_r >= POS_MIN_IDENT) begin
        rec.echo_ident = ident_nxt;
      end
    end
  end

  assign rec_valid = beat_acc && last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || rec_valid) begin
      cnt_r   <= '0;
      type_r  <= '0;
      code_r  <= '0;
      ident_r <= '0;
      ihl_r   <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      sport_r <= '0;
      dport_r <= '0;
    end else if (beat_acc) begin
      cnt_r   <= cnt_nxt;
      type_r  <= type_nxt;
      code_r  <= code_nxt;
      ident_r <= ident_nxt;
      ihl_r   <= ihl_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
    end
  end

endmodule

/* hw/rtl/ihfe_out_skid.sv */
// ----------------------------------------------------------------------------
// ihfe_out_skid: two-entry result register with skid slot
// Holds records for the output channel; ready upstream is a flop.
// ----------------------------------------------------------------------------
module ihfe_out_skid
  import ihfe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic can_push,
  output logic out_valid,
  input  logic out_ready,
  output rec_t out_rec
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  rec_t out_rec_r, out_rec_nxt;
  rec_t skid_rec_r, skid_rec_nxt;
  logic pop;

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_rec_nxt    = out_rec_r;
    skid_rec_nxt   = skid_rec_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_rec_nxt    = skid_rec_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_rec_nxt = push_rec;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_rec_nxt   = push_rec;
        out_valid_nxt = 1'b1;
      end else begin
        skid_rec_nxt   = push_rec;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r  <= out_rec_nxt;
    skid_rec_r <= skid_rec_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

endmodule

/* hw/rtl/ihfe_checker.sv */
// ----------------------------------------------------------------------------
// ihfe_checker: port-level checks for the ICMP header field extractor
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module ihfe_checker
  import ihfe_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a valid unreachable record always quotes UDP
  a_unr_proto: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[136:129] == PROTO_UDP)
    else $error("unreachable record without UDP protocol");

  // quoted fields are zero unless the unreachable record is valid
  a_unr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[143:33] == '0)
    else $error("quoted fields set without valid unreachable record");

  // a fresh result only follows a final input byte
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast))
    else $error("result beat without a final input byte");

endmodule

bind icmp_header_field_extractor ihfe_checker u_ihfe_checker (.*);

/* bench/icmp_header_field_extractor_tb.sv */
// ----------------------------------------------------------------------------
// icmp_header_field_extractor_tb: self-checking bench for the ICMP extractor
// Streams ICMP messages into the block byte by byte, predicts each record
// from its own copy of the capture state and checks every result beat.
// ----------------------------------------------------------------------------
// A directed set comes first: short messages, each identifier type, port
// unreachable with small, normal and largest IHL, truncated quotes and a
// wrong quoted protocol. Random messages follow, mostly well-formed port
// unreachable and echo family, with the rest noise. Three phases vary the
// idling of both sides.
// ----------------------------------------------------------------------------
module icmp_header_field_extractor_tb;
  import ihfe_pkg::*;

  localparam int STALL_LIMIT = 2000;   // cycles with no beat moving at all
  localparam int DRAIN_CYCLES = 16;
  localparam int QUOTE_MIN_LEN = 28;   // ICMP header plus minimal IPv4 header
  localparam int UDP_HDR_LEN = 8;

  localparam logic [7:0] CODE_HOST_UNR = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold;   // wait for every outstanding record before sending
  } beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'd0;   // [7:0] data_byte
  logic                   in_tlast = 1'b0;   // last_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // record, msg_type in the low byte

  beat_t byte_q[$];        // bytes waiting to be driven
  rec_t  pending_recs[$];  // records predicted but not yet seen
  logic  in_taken = 1'b0;  // input beat accepted at the last rising edge
  int    in_idle_pct = 0;
  int    out_idle_pct = 0;
  int    mismatch_cnt = 0;
  int    stall_cnt = 0;

  // predictor state: mirrors the block's capture registers
  logic [15:0] pos_cnt = '0;
  logic [7:0]  msg_type_q = '0;
  logic [7:0]  msg_code_q = '0;
  logic [15:0] ident_q = '0;
  logic [3:0]  ihl_q = '0;
  logic [7:0]  proto_q = '0;
  logic [31:0] src_addr_q = '0;
  logic [31:0] dst_addr_q = '0;
  logic [15:0] src_port_q = '0;
  logic [15:0] dst_port_q = '0;

  icmp_header_field_extractor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Captures one accepted byte; on the final byte forms the record and
  // clears the state for the next message.
  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    int unsigned base;
    int unsigned len;
    int          sh;
    rec_t        r;
    if (pos_cnt == POS_TYPE) msg_type_q = b;
    if (pos_cnt == POS_CODE) msg_code_q = b;
    if (pos_cnt == POS_IDENT_HI) ident_q[15:8] = b;
    if (pos_cnt == POS_IDENT_LO) ident_q[7:0] = b;
    if (pos_cnt == POS_IHL) ihl_q = b[3:0];
    if (pos_cnt == POS_PROTO) proto_q = b;
    if (pos_cnt >= POS_SRC_FIRST && pos_cnt <= POS_SRC_LAST) begin
      sh = 8 * (int'(POS_SRC_LAST) - int'(pos_cnt));
      src_addr_q[sh +: 8] = b;
    end
    if (pos_cnt >= POS_DST_FIRST && pos_cnt <= POS_DST_LAST) begin
      sh = 8 * (int'(POS_DST_LAST) - int'(pos_cnt));
      dst_addr_q[sh +: 8] = b;
    end
    // ports sit after the quoted header; IHL taken on this very byte counts
    base = int'(POS_IHL) + 4 * int'(ihl_q);
    if (pos_cnt == base) src_port_q[15:8] = b;
    if (pos_cnt == base + 1) src_port_q[7:0] = b;
    if (pos_cnt == base + 2) dst_port_q[15:8] = b;
    if (pos_cnt == base + 3) dst_port_q[7:0] = b;
    len = int'(pos_cnt) + 1;
    if (pos_cnt != CNT_MAX) pos_cnt = pos_cnt + 16'd1;
    if (fin) begin
      r = '0;
      if (len > 2) begin
        r.msg_type = msg_type_q;
        r.msg_code = msg_code_q;
        if (msg_type_q == TYPE_UNREACH && msg_code_q == CODE_PORT_UNR) begin
          if (len >= QUOTE_MIN_LEN && len >= base + UDP_HDR_LEN && proto_q == PROTO_UDP) begin
            r.unreach_valid   = 1'b1;
            r.quoted_src_addr = src_addr_q;
            r.quoted_dst_addr = dst_addr_q;
            r.quoted_src_port = src_port_q;
            r.quoted_dst_port = dst_port_q;
            r.quoted_proto    = proto_q;
          end
        end else if (msg_code_q == CODE_ZERO && len > 5 &&
                     (msg_type_q == TYPE_ECHO_REPLY || msg_type_q == TYPE_ECHO_REQ ||
                      msg_type_q == TYPE_TS_REQ || msg_type_q == TYPE_TS_REPLY ||
                      msg_type_q == TYPE_INFO_REQ || msg_type_q == TYPE_INFO_REPLY)) begin
          r.echo_ident = ident_q;
        end
      end
      pending_recs.push_back(r);
      pos_cnt = '0;
      msg_type_q = '0;
      msg_code_q = '0;
      ident_q = '0;
      ihl_q = '0;
      proto_q = '0;
      src_addr_q = '0;
      dst_addr_q = '0;
      src_port_q = '0;
      dst_port_q = '0;
    end
  endtask

  function automatic void cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Builds a message of random bytes with the header fields forced, and
  // queues it a byte per beat with tlast on the final one.
  task automatic queue_msg(input logic [7:0] t, input logic [7:0] c, input logic [3:0] ihl,
                           input logic [7:0] proto, input int len, input bit hold);
    beat_t      bt;
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      if (i == POS_TYPE) d = t;
      else if (i == POS_CODE) d = c;
      else if (i == POS_IHL) d = {d[7:4], ihl};
      else if (i == POS_PROTO) d = proto;
      bt.data = d;
      bt.last = (i == len - 1);
      bt.hold = hold && (i == 0);
      byte_q.push_back(bt);
    end
  endtask

  // Driver: presents a new byte once the previous one has gone; idles only
  // between beats so tvalid never drops under a pending beat.
  always @(negedge clk) begin : drive_proc
    beat_t bt;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
      if (!in_tvalid || in_taken) begin
        if (byte_q.size() > 0 && !(byte_q[0].hold && pending_recs.size() > 0) &&
            $urandom_range(99) >= in_idle_pct) begin
          bt = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= bt.data;
          in_tlast  <= bt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result beats against the oldest prediction, then feeds
  // the accepted input byte to the predictor.
  always @(posedge clk) begin : watch_proc
    rec_t want;
    rec_t got;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = rec_t'(out_tdata[REC_W-1:0]);
        if (pending_recs.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: record mismatch: expected none, actual %0h", $time, out_tdata);
        end else begin
          want = pending_recs.pop_front();
          cmp("msg_type", 32'(want.msg_type), 32'(got.msg_type));
          cmp("msg_code", 32'(want.msg_code), 32'(got.msg_code));
          cmp("echo_ident", 32'(want.echo_ident), 32'(got.echo_ident));
          cmp("unreach_valid", 32'(want.unreach_valid), 32'(got.unreach_valid));
          cmp("quoted_src_addr", want.quoted_src_addr, got.quoted_src_addr);
          cmp("quoted_dst_addr", want.quoted_dst_addr, got.quoted_dst_addr);
          cmp("quoted_src_port", 32'(want.quoted_src_port), 32'(got.quoted_src_port));
          cmp("quoted_dst_port", 32'(want.quoted_dst_port), 32'(got.quoted_dst_port));
          cmp("quoted_proto", 32'(want.quoted_proto), 32'(got.quoted_proto));
          cmp("tdata padding", 32'd0, 32'(out_tdata[OUT_TDATA_W-1:REC_W]));
        end
      end
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tlast);
    end
  end

  // Watchdog: any beat moving on either side counts as progress
  always @(posedge clk) begin : stall_proc
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [7:0] ident_types[6];
    logic [7:0] t;
    logic [7:0] c;
    logic [7:0] proto;
    logic [3:0] ihl;
    int         len;
    int         need;
    int         k;
    int         n_msgs;
    int         n_bytes;
    ident_types = '{TYPE_ECHO_REPLY, TYPE_ECHO_REQ, TYPE_TS_REQ,
                    TYPE_TS_REPLY, TYPE_INFO_REQ, TYPE_INFO_REPLY};
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin in_idle_pct = 34; out_idle_pct = 50; end
        1: begin in_idle_pct = 50; out_idle_pct = 34; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase

      if (phase == 0) begin
        // short messages: one, two and three bytes
        queue_msg(TYPE_ECHO_REQ, CODE_ZERO, 4'd5, PROTO_UDP, 1, 1'b0);
        queue_msg(TYPE_ECHO_REQ, CODE_ZERO, 4'd5, PROTO_UDP, 2, 1'b0);
        queue_msg(8'hFF, 8'hFF, 4'd5, PROTO_UDP, 3, 1'b0);
        // identifier just too short, then just long enough
        queue_msg(TYPE_ECHO_REQ, CODE_ZERO, 4'd5, PROTO_UDP, 5, 1'b0);
        queue_msg(TYPE_ECHO_REQ, CODE_ZERO, 4'd5, PROTO_UDP, 6, 1'b0);
        foreach (ident_types[i]) queue_msg(ident_types[i], CODE_ZERO, 4'd5, PROTO_UDP, 8, 1'b0);
        queue_msg(TYPE_ECHO_REQ, CODE_HOST_UNR, 4'd5, PROTO_UDP, 8, 1'b0);
        // port unreachable around the length limits and IHL extremes
        queue_msg(TYPE_UNREACH, CODE_PORT_UNR, 4'd5, PROTO_UDP, 36, 1'b1);
        queue_msg(TYPE_UNREACH, CODE_PORT_UNR, 4'd5, PROTO_UDP, 35, 1'b0);
        queue_msg(TYPE_UNREACH, CODE_PORT_UNR, 4'd5, PROTO_UDP, 27, 1'b0);
        queue_msg(TYPE_UNREACH, CODE_PORT_UNR, 4'd0, PROTO_UDP, 28, 1'b0);
        queue_msg(TYPE_UNREACH, CODE_PORT_UNR, 4'd15, PROTO_UDP, 76, 1'b0);
        queue_msg(TYPE_UNREACH, CODE_PORT_UNR, 4'd15, PROTO_UDP, 75, 1'b0);
        queue_msg(TYPE_UNREACH, CODE_PORT_UNR, 4'd5, PROTO_TCP, 36, 1'b0);
        queue_msg(TYPE_UNREACH, CODE_HOST_UNR, 4'd5, PROTO_UDP, 36, 1'b0);
      end

      n_msgs = 0;
      n_bytes = 0;
      while (n_msgs < 3 || n_bytes < 25) begin
        k = $urandom_range(99);
        if (k < 50) begin
          // port unreachable quoting UDP, a share of them cut short
          ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd5;
          need = int'(POS_IHL) + 4 * int'(ihl) + UDP_HDR_LEN;
          if (need < QUOTE_MIN_LEN) need = QUOTE_MIN_LEN;
          len = need - 3 + $urandom_range(9);
          proto = ($urandom_range(7) == 0) ? 8'($urandom) : PROTO_UDP;
          c = ($urandom_range(9) == 0) ? 8'($urandom) : CODE_PORT_UNR;
          queue_msg(TYPE_UNREACH, c, ihl, proto, len, 1'b0);
        end else if (k < 80) begin
          t = ident_types[$urandom_range(5)];
          c = ($urandom_range(5) == 0) ? 8'($urandom) : CODE_ZERO;
          len = $urandom_range(12, 1);
          queue_msg(t, c, 4'($urandom), 8'($urandom), len, 1'b0);
        end else begin
          len = $urandom_range(40, 1);
          queue_msg(8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom), len, 1'b0);
        end
        n_msgs++;
        n_bytes += len;
      end

      while (!(byte_q.size() == 0 && !in_tvalid && pending_recs.size() == 0))
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_recs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ihfe_pkg.sv
hw/rtl/ihfe_capture.sv
hw/rtl/ihfe_out_skid.sv
hw/rtl/icmp_header_field_extractor.sv
hw/rtl/ihfe_checker.sv
bench/icmp_header_field_extractor_tb.sv
